@@ design/binary_max_heap_queue_core_macros.svh @@
// Assertion macros shared by the heap queue checker.
// Included by file name where assertions are written; no other dependencies.
`ifndef BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define BMHQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmhq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low)
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmhq: next-cycle check failed");

`endif

@@ design/bmhq_pkg.sv @@
// Package for the binary max-heap priority queue: field widths, action and
// status codes. No dependencies.
package bmhq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TOTAL_W = 11;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [TOTAL_W-1:0]        total_t;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

@@ design/bmhq_if.sv @@
// Valid/ready channel interfaces for the heap queue: request and result.
// Depends on bmhq_pkg.
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  value_t value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface bmhq_out_if;
  import bmhq_pkg::*;

  logic    valid;
  logic    ready;
  value_t  top_value;
  total_t  entry_total;
  status_e status;

  modport source (output valid, output top_value, output entry_total, output status,
                  input ready);
  modport sink   (input valid, input top_value, input entry_total, input status,
                  output ready);
endinterface

@@ design/binary_max_heap_queue_core.sv @@
// Binary max-heap priority queue core: heap memory, one shared signed
// comparator and a one-hot sequencer. Depends on bmhq_pkg and bmhq_if.
//
//   channel | dir | transfer when       | payload
//   in_i    | in  | valid & ready       | action, value
//   out_o   | out | valid & ready       | top_value, entry_total, status
//
// Insert: read and compare each parent, then place. Delete: load the last entry, then
// per level read the children, pick the larger and move it up or place. Every item then
// reads the top; a dropped insert, an empty delete or removing the only entry skip to it.
// One item is in work at a time; in_i.ready is high only when the sequencer idles.
// The result sits in an output register; the next item may be taken while it waits,
// and only a second result stalls on out_o. Reset clears count and control state.
module binary_max_heap_queue_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bmhq_in_if.sink       in_i,
  bmhq_out_if.source    out_o
);
  import bmhq_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CHD_W = IDX_W + 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CHD_W-1:0] chd_t;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_UP_RD   = 12'b0000_0000_0010,
    S_UP_CMP  = 12'b0000_0000_0100,
    S_PLACE   = 12'b0000_0000_1000,
    S_DN_LAST = 12'b0000_0001_0000,
    S_DN_LOAD = 12'b0000_0010_0000,
    S_DN_RDL  = 12'b0000_0100_0000,
    S_DN_RDR  = 12'b0000_1000_0000,
    S_DN_CMP  = 12'b0001_0000_0000,
    S_DN_MOVE = 12'b0010_0000_0000,
    S_TOP_RD  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  idx_t    pos_q, pos_d;
  value_t  cur_q, cur_d;
  value_t  lv_q, lv_d;
  value_t  cval_q, cval_d;
  idx_t    cidx_q, cidx_d;
  logic    has_right_q, has_right_d;
  status_e status_q, status_d;

  logic    out_valid_q, out_valid_d;
  value_t  top_q, top_d;
  total_t  tot_q, tot_d;
  status_e stat_out_q, stat_out_d;

  // Heap memory: one write and one registered read per cycle
  value_t  mem_q [CAPACITY];
  value_t  rdata_q;
  logic    mem_we, mem_re;
  idx_t    mem_waddr, mem_raddr;
  value_t  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Index arithmetic
  idx_t pos_m1, parent;
  chd_t left_w, right_w, count_w;
  logic in_xfer, full, load_out;
  logic [CNT_W+TOTAL_W-1:0] count_ext;

  assign pos_m1    = pos_q - idx_t'(1);
  assign parent    = pos_m1 >> 1;
  assign left_w    = {1'b0, pos_q, 1'b1};
  assign right_w   = left_w + chd_t'(1);
  assign count_w   = chd_t'(count_q);
  assign full      = (count_q == cnt_t'(CAPACITY));
  assign in_xfer   = in_i.valid && in_i.ready;
  assign count_ext = {{TOTAL_W{1'b0}}, count_q};

  // Shared signed comparator: cmp_a < cmp_b
  value_t cmp_a, cmp_b;
  logic   cmp_lt;

  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = rdata_q;
        cmp_b = cur_q;
      end
      S_DN_CMP: begin
        cmp_a = lv_q;
        cmp_b = rdata_q;
      end
      S_DN_MOVE: begin
        cmp_a = cur_q;
        cmp_b = cval_q;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    lv_d        = lv_q;
    cval_d      = cval_q;
    cidx_d      = cidx_q;
    has_right_d = has_right_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = pos_q;
    mem_raddr   = '0;
    mem_wdata   = cur_q;
    load_out    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          status_d = STATUS_OK;
          if (in_i.action == ACT_INSERT) begin
            if (full) begin
              status_d = STATUS_FULL;
              state_d  = S_TOP_RD;
            end else begin
              pos_d   = count_q[IDX_W-1:0];
              cur_d   = in_i.value;
              count_d = count_q + cnt_t'(1);
              state_d = (count_q == '0) ? S_PLACE : S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_TOP_RD;
            end else begin
              count_d = count_q - cnt_t'(1);
              state_d = (count_q == cnt_t'(1)) ? S_TOP_RD : S_DN_LAST;
            end
          end
        end
      end
      // Sift up: pull smaller parents down into the hole
      S_UP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = parent;
        state_d   = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_lt) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q;
          pos_d     = parent;
          state_d   = (parent == '0) ? S_PLACE : S_UP_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        mem_we  = 1'b1;
        state_d = S_TOP_RD;
      end
      // Sift down: last entry becomes the moving value, root is the hole
      S_DN_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = count_q[IDX_W-1:0];
        pos_d     = '0;
        state_d   = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cur_d   = rdata_q;
        state_d = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_w >= count_w) begin
          state_d = S_PLACE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = left_w[IDX_W-1:0];
          state_d   = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        lv_d        = rdata_q;
        has_right_d = (right_w < count_w);
        mem_re      = (right_w < count_w);
        mem_raddr   = right_w[IDX_W-1:0];
        state_d     = S_DN_CMP;
      end
      S_DN_CMP: begin
        // Larger child; a tie goes to the left
        if (has_right_q && cmp_lt) begin
          cval_d = rdata_q;
          cidx_d = right_w[IDX_W-1:0];
        end else begin
          cval_d = lv_q;
          cidx_d = left_w[IDX_W-1:0];
        end
        state_d = S_DN_MOVE;
      end
      S_DN_MOVE: begin
        if (cmp_lt) begin
          mem_we    = 1'b1;
          mem_wdata = cval_q;
          pos_d     = cidx_q;
          state_d   = S_DN_RDL;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_TOP_RD: begin
        mem_re    = (count_q != '0);
        mem_raddr = '0;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = load_out || (out_valid_q && !out_o.ready);
    top_d       = top_q;
    tot_d       = tot_q;
    stat_out_d  = stat_out_q;
    if (load_out) begin
      top_d      = (count_q != '0) ? rdata_q : '0;
      tot_d      = count_ext[TOTAL_W-1:0];
      stat_out_d = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    cur_q       <= cur_d;
    lv_q        <= lv_d;
    cval_q      <= cval_d;
    cidx_q      <= cidx_d;
    has_right_q <= has_right_d;
    status_q    <= status_d;
    top_q       <= top_d;
    tot_q       <= tot_d;
    stat_out_q  <= stat_out_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.top_value   = top_q;
  assign out_o.entry_total = tot_q;
  assign out_o.status      = stat_out_q;

endmodule

@@ design/bmhq_checker.sv @@
// Port-level checks for the heap queue core, with the bind that attaches them.
// Depends on bmhq_pkg and binary_max_heap_queue_core_macros.svh.
`include "binary_max_heap_queue_core_macros.svh"

module bmhq_checker #(
  parameter int unsigned CAPACITY = 1024
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input bmhq_pkg::value_t  top_value_i,
  input bmhq_pkg::total_t  entry_total_i,
  input bmhq_pkg::status_e status_i
);
  import bmhq_pkg::*;

  localparam total_t FULL_TOTAL = TOTAL_W'(CAPACITY);

  // A stalled result holds its payload
  `BMHQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(top_value_i) && $stable(entry_total_i) && $stable(status_i))

  // One item at a time: no request taken right after a transfer in
  `BMHQ_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // Dropped insert only when the heap is full
  `BMHQ_ASSERT_NOW(a_full_total, clk_i, rst_ni, out_valid_i && status_i == STATUS_FULL, entry_total_i == FULL_TOTAL)

  // Delete on empty leaves an empty heap with a zero top
  `BMHQ_ASSERT_NOW(a_empty_result, clk_i, rst_ni, out_valid_i && status_i == STATUS_EMPTY, entry_total_i == '0 && top_value_i == '0)

  // An empty heap reports a zero top (checked only for CAPACITY below 2048)
  `BMHQ_ASSERT_NOW(a_zero_top, clk_i, rst_ni, out_valid_i && entry_total_i == '0 && CAPACITY < 2048, top_value_i == '0)

endmodule

bind binary_max_heap_queue_core bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .top_value_i   (out_o.top_value),
  .entry_total_i (out_o.entry_total),
  .status_i      (out_o.status)
);
